[rtl/dlf_pkg.sv]
`default_nettype none
package dlf_pkg;

  localparam int MaxIn    = 256;
  localparam int MaxOut   = 64;
  localparam int RowW     = 8;
  localparam int ColW     = 6;
  localparam int AddrW    = RowW + ColW;
  localparam int InLenW   = 9;
  localparam int OutLenW  = 7;
  localparam int CfgDataW = 9;

  localparam logic [31:0] QNan = 32'h7FC0_0000;

  typedef enum logic {
    FUNC_WEIGHT = 1'b0,
    FUNC_ACT    = 1'b1
  } func_e;

  typedef enum logic {
    CFG_IN_LEN  = 1'b0,
    CFG_OUT_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic            func;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [31:0]     value;
    logic            last_element;
  } in_item_t;

  typedef struct packed {
    logic [ColW-1:0] out_index;
    logic [31:0]     out_value;
    logic            last_result;
  } out_item_t;

  // travels with each fma operation
  typedef struct packed {
    logic [ColW-1:0] idx;
    logic            last;
  } fma_tag_t;

  // index of the highest set bit, zero for zero
  function automatic logic [5:0] top_bit(input logic [62:0] v);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) k = 6'(i);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

[rtl/dense_layer_forward_fp32_top.sv]
// dense layer forward, fp32: out[o] = sum over i of x[i] * w[i][o]
// weight item: busy stays low; ignored item: busy stays low
// activation item: busy until its last output leaves the fma (one issue per output
// through the shared 5-stage fma pipe, after a memory read register)
// results leave on out_valid_o, one per cycle, and cannot be stalled
// reset: in_len 256, out_len 64, accumulators +0; weight store undefined
`default_nettype none
module dense_layer_forward_fp32_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire dlf_pkg::in_item_t            in_i,
  output logic                              out_valid_o,
  output dlf_pkg::out_item_t                out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [dlf_pkg::CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [dlf_pkg::InLenW-1:0]  in_len_q;
  logic [dlf_pkg::OutLenW-1:0] out_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q  <= dlf_pkg::InLenW'(dlf_pkg::MaxIn);
      out_len_q <= dlf_pkg::OutLenW'(dlf_pkg::MaxOut);
    end else if (cfg_we_i) begin
      unique case (dlf_pkg::cfg_idx_e'(cfg_idx_i))
        dlf_pkg::CFG_IN_LEN:  in_len_q  <= cfg_data_i;
        dlf_pkg::CFG_OUT_LEN: out_len_q <= cfg_data_i[dlf_pkg::OutLenW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, zero acts as one, clamp to the store size
  logic [dlf_pkg::InLenW-1:0]  ni;
  logic [dlf_pkg::OutLenW-1:0] no;

  always_comb begin
    ni = in_len_q;
    if (in_len_q == '0) ni = dlf_pkg::InLenW'(1);
    else if (in_len_q > dlf_pkg::InLenW'(dlf_pkg::MaxIn)) ni = dlf_pkg::InLenW'(dlf_pkg::MaxIn);
    no = out_len_q;
    if (out_len_q == '0) no = dlf_pkg::OutLenW'(1);
    else if (out_len_q > dlf_pkg::OutLenW'(dlf_pkg::MaxOut)) no = dlf_pkg::OutLenW'(dlf_pkg::MaxOut);
  end

  // item decode
  logic accept, row_ok, w_go, a_go;

  assign accept = start_i && !busy_o;
  assign row_ok = ({1'b0, in_i.row} < ni);
  assign w_go   = accept && row_ok && (in_i.func == dlf_pkg::FUNC_WEIGHT) &&
                  ({1'b0, in_i.col} < no);
  assign a_go   = accept && row_ok && (in_i.func == dlf_pkg::FUNC_ACT);

  // latched activation element
  logic [dlf_pkg::RowW-1:0] row_q;
  logic [31:0]              x_q;
  logic                     last_q;

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      row_q  <= in_i.row;
      x_q    <= in_i.value;
      last_q <= in_i.last_element;
    end
  end

  // sequencer
  dlf_pkg::state_e          state_q, state_d;
  logic [dlf_pkg::ColW-1:0] cnt_q, cnt_d;
  logic                     issue;
  logic                     cnt_end;
  logic                     fma_v;
  dlf_pkg::fma_tag_t        fma_tag;
  logic [31:0]              fma_res;
  logic                     fin;

  assign cnt_end = ({1'b0, cnt_q} == (no - dlf_pkg::OutLenW'(1)));
  assign fin     = fma_v && ({1'b0, fma_tag.idx} == (no - dlf_pkg::OutLenW'(1)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlf_pkg::ST_IDLE:  if (a_go) state_d = dlf_pkg::ST_ISSUE;
      dlf_pkg::ST_ISSUE: if (cnt_end) state_d = dlf_pkg::ST_DRAIN;
      dlf_pkg::ST_DRAIN: if (fin) state_d = dlf_pkg::ST_IDLE;
      default:           state_d = dlf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o = 1'b1;
    issue  = 1'b0;
    cnt_d  = cnt_q;
    unique case (state_q)
      dlf_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        cnt_d  = '0;
      end
      dlf_pkg::ST_ISSUE: begin
        issue = 1'b1;
        cnt_d = cnt_q + dlf_pkg::ColW'(1);
      end
      dlf_pkg::ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // memory read register before the fma
  logic              rd_v_q;
  dlf_pkg::fma_tag_t rd_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_v_q <= 1'b0;
    else rd_v_q <= issue;
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q.idx  <= cnt_q;
    rd_tag_q.last <= last_q;
  end

  logic [31:0] w_rdata, acc_rdata;

  dlf_wmem u_wmem (
    .clk_i   (clk_i),
    .we_i    (w_go),
    .waddr_i ({in_i.row, in_i.col}),
    .wdata_i (in_i.value),
    .raddr_i ({row_q, cnt_q}),
    .rdata_o (w_rdata)
  );

  // row 0 restarts every accumulator at +0
  dlf_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (a_go && (in_i.row == '0)),
    .we_i    (fma_v),
    .waddr_i (fma_tag.idx),
    .wdata_i (fma_res),
    .raddr_i (cnt_q),
    .rdata_o (acc_rdata)
  );

  dlf_fma u_fma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_v_q),
    .in_tag_i    (rd_tag_q),
    .a_i         (x_q),
    .b_i         (w_rdata),
    .c_i         (acc_rdata),
    .out_valid_o (fma_v),
    .out_tag_o   (fma_tag),
    .res_o       (fma_res)
  );

  // the last element of a vector streams each updated accumulator out
  assign out_valid_o       = fma_v && fma_tag.last;
  assign out_o.out_index   = fma_tag.idx;
  assign out_o.out_value   = fma_res;
  assign out_o.last_result = fin;

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result outside an item");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last_result) |=> !busy_o)
    else $error("busy after final result");

  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_go |=> (busy_o && !out_valid_o))
    else $error("activation item not started");

endmodule
`default_nettype wire

[rtl/dlf_wmem.sv]
`default_nettype none
module dlf_wmem (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [dlf_pkg::AddrW-1:0] waddr_i,
  input  wire logic [31:0]               wdata_i,
  input  wire logic [dlf_pkg::AddrW-1:0] raddr_i,
  output logic [31:0]                    rdata_o
);

  logic [31:0] mem_q [dlf_pkg::MaxIn*dlf_pkg::MaxOut];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/dlf_acc.sv]
`default_nettype none
module dlf_acc (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clr_i,
  input  wire logic                     we_i,
  input  wire logic [dlf_pkg::ColW-1:0] waddr_i,
  input  wire logic [31:0]              wdata_i,
  input  wire logic [dlf_pkg::ColW-1:0] raddr_i,
  output logic [31:0]                   rdata_o
);

  logic [31:0]               mem_q [dlf_pkg::MaxOut];
  logic [dlf_pkg::MaxOut-1:0] vld_q;
  logic [31:0]               data_q;
  logic                      rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    data_q <= mem_q[raddr_i];
  end

  // cleared entries read as +0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) vld_q <= '0;
      else if (we_i) vld_q[waddr_i] <= 1'b1;
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? data_q : 32'h0;

endmodule
`default_nettype wire

[rtl/dlf_fma.sv]
`default_nettype none
module dlf_fma (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire dlf_pkg::fma_tag_t in_tag_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [31:0]       b_i,
  input  wire logic [31:0]       c_i,
  output logic                   out_valid_o,
  output dlf_pkg::fma_tag_t      out_tag_o,
  output logic [31:0]            res_o
);

  // stage 0: unpack, special cases, mantissa product
  logic        sa, sb, sc, ps;
  logic [7:0]  xa, xb, xc;
  logic [22:0] fa, fb, fc;
  logic        az, bz, cz, cinf, anyn;
  logic        spec0;
  logic [31:0] sval0;
  logic [23:0] ma, mb, mc;

  always_comb begin
    sa = a_i[31]; sb = b_i[31]; sc = c_i[31]; ps = sa ^ sb;
    xa = a_i[30:23]; xb = b_i[30:23]; xc = c_i[30:23];
    fa = a_i[22:0]; fb = b_i[22:0]; fc = c_i[22:0];
    az = (a_i[30:0] == '0);
    bz = (b_i[30:0] == '0);
    cz = (c_i[30:0] == '0);
    cinf = (xc == 8'hFF) && (fc == '0);
    anyn = ((xa == 8'hFF) && (fa != '0)) || ((xb == 8'hFF) && (fb != '0)) ||
           ((xc == 8'hFF) && (fc != '0));
    ma = {(xa != '0), fa};
    mb = {(xb != '0), fb};
    mc = {(xc != '0), fc};
    spec0 = 1'b1;
    sval0 = dlf_pkg::QNan;
    if (anyn) begin
      sval0 = dlf_pkg::QNan;
    end else if ((xa == 8'hFF) || (xb == 8'hFF)) begin
      if (az || bz || (cinf && (sc != ps))) sval0 = dlf_pkg::QNan;
      else sval0 = {ps, 8'hFF, 23'h0};
    end else if (cinf) begin
      sval0 = c_i;
    end else if (az || bz) begin
      sval0 = cz ? {ps & sc, 31'h0} : c_i;
    end else begin
      spec0 = 1'b0;
    end
  end

  logic                     v1_q, spec1_q, ps1_q, sc1_q, cz1_q;
  logic [31:0]              sval1_q;
  logic [47:0]              pm1_q;
  logic [23:0]              cm1_q;
  logic signed [11:0]       pe1_q, ce1_q;
  dlf_pkg::fma_tag_t        tag1_q;

  always_ff @(posedge clk_i) begin
    spec1_q <= spec0;
    sval1_q <= sval0;
    ps1_q   <= ps;
    sc1_q   <= sc;
    cz1_q   <= cz;
    pm1_q   <= ma * mb;
    cm1_q   <= mc;
    pe1_q   <= 12'((xa != '0) ? xa : 8'd1) + 12'((xb != '0) ? xb : 8'd1) - 12'd300;
    ce1_q   <= 12'((xc != '0) ? xc : 8'd1) - 12'd150;
    tag1_q  <= in_tag_i;
  end

  // stage 1: bring both operands to the top at bit 61
  logic [5:0] tp, tc, np, nc;

  always_comb begin
    tp = dlf_pkg::top_bit(63'(pm1_q));
    tc = dlf_pkg::top_bit(63'(cm1_q));
    np = 6'd61 - tp;
    nc = 6'd61 - tc;
  end

  logic                     v2_q, spec2_q, ps2_q, sc2_q, cz2_q;
  logic [31:0]              sval2_q;
  logic [61:0]              pm2_q, cm2_q;
  logic signed [11:0]       pe2_q, ce2_q;
  dlf_pkg::fma_tag_t        tag2_q;

  always_ff @(posedge clk_i) begin
    spec2_q <= spec1_q;
    sval2_q <= sval1_q;
    ps2_q   <= ps1_q;
    sc2_q   <= sc1_q;
    cz2_q   <= cz1_q;
    pm2_q   <= 62'(pm1_q) << np;
    cm2_q   <= 62'(cm1_q) << nc;
    pe2_q   <= pe1_q - $signed({6'b0, np});
    ce2_q   <= ce1_q - $signed({6'b0, nc});
    tag2_q  <= tag1_q;
  end

  // stage 2: order, align with sticky, add or subtract
  logic               swap, bs, ss;
  logic [61:0]        bm, sm, sma;
  logic signed [11:0] be, se, d;
  logic [62:0]        r2;
  logic signed [11:0] e2;
  logic               s2;

  always_comb begin
    swap = !((pe2_q > ce2_q) || ((pe2_q == ce2_q) && (pm2_q >= cm2_q)));
    bm = swap ? cm2_q : pm2_q;
    be = swap ? ce2_q : pe2_q;
    bs = swap ? sc2_q : ps2_q;
    sm = swap ? pm2_q : cm2_q;
    se = swap ? pe2_q : ce2_q;
    ss = swap ? ps2_q : sc2_q;
    d  = be - se;
    if (d >= 12'sd63) begin
      sma = {61'h0, (sm != '0)};
    end else if (d > 12'sd0) begin
      sma = (sm >> d[5:0]);
      sma[0] = sma[0] | (((sm >> d[5:0]) << d[5:0]) != sm);
    end else begin
      sma = sm;
    end
    if (cz2_q) begin
      r2 = {1'b0, pm2_q};
      e2 = pe2_q;
      s2 = ps2_q;
    end else begin
      r2 = (bs == ss) ? ({1'b0, bm} + {1'b0, sma}) : ({1'b0, bm} - {1'b0, sma});
      e2 = be;
      s2 = bs;
    end
  end

  logic                     v3_q, spec3_q, s3_q;
  logic [31:0]              sval3_q;
  logic [62:0]              r3_q;
  logic signed [11:0]       e3_q;
  dlf_pkg::fma_tag_t        tag3_q;

  always_ff @(posedge clk_i) begin
    // exact cancellation gives +0
    spec3_q <= spec2_q || (r2 == '0);
    sval3_q <= spec2_q ? sval2_q : 32'h0;
    s3_q    <= s2;
    r3_q    <= r2;
    e3_q    <= e2;
    tag3_q  <= tag2_q;
  end

  // stage 3: leading one and rounding position
  logic signed [11:0] sh3, lim3;

  always_comb begin
    sh3  = $signed({6'b0, dlf_pkg::top_bit(r3_q)}) - 12'sd23;
    lim3 = -12'sd149 - e3_q;
    if (lim3 > sh3) sh3 = lim3;
  end

  logic                     v4_q, spec4_q, s4_q;
  logic [31:0]              sval4_q;
  logic [62:0]              r4_q;
  logic signed [11:0]       e4_q, sh4_q;
  dlf_pkg::fma_tag_t        tag4_q;

  always_ff @(posedge clk_i) begin
    spec4_q <= spec3_q;
    sval4_q <= sval3_q;
    s4_q    <= s3_q;
    r4_q    <= r3_q;
    e4_q    <= e3_q;
    sh4_q   <= sh3;
    tag4_q  <= tag3_q;
  end

  // stage 4: shift, round to nearest even, pack
  logic [63:0]        m4, q, rem, half, mask;
  logic signed [11:0] scale, ex;
  logic [31:0]        res4;

  always_comb begin
    m4    = {1'b0, r4_q};
    q     = '0;
    rem   = '0;
    half  = '0;
    mask  = '0;
    scale = e4_q + sh4_q;
    ex    = '0;
    res4  = {s4_q, 31'h0};
    if (sh4_q < 12'sd64) begin
      if (sh4_q <= 12'sd0) begin
        q = m4 << 6'(-sh4_q);
      end else begin
        mask = (64'h1 << sh4_q[5:0]) - 64'h1;
        rem  = m4 & mask;
        half = 64'h1 << 6'(sh4_q - 12'sd1);
        q    = m4 >> sh4_q[5:0];
        if ((rem > half) || ((rem == half) && q[0])) q = q + 64'h1;
      end
      if (q[24]) begin
        q = q >> 1;
        scale = scale + 12'sd1;
      end
      if (q[23]) begin
        ex = scale + 12'sd150;
        if (ex >= 12'sd255) res4 = {s4_q, 8'hFF, 23'h0};
        else res4 = {s4_q, ex[7:0], q[22:0]};
      end else begin
        res4 = {s4_q, 8'h0, q[22:0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_o     <= spec4_q ? sval4_q : res4;
    out_tag_o <= tag4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      out_valid_o <= v4_q;
    end
  end

endmodule
`default_nettype wire
